@@ src/lte_pkg.sv @@
package lte_pkg;

   // ASCII codes that the classifier and the trimmer look at.
   localparam logic [7:0] CHAR_LF          = 8'd10;
   localparam logic [7:0] CHAR_CR          = 8'd13;
   localparam logic [7:0] CHAR_PRINT_LOW   = 8'd32;
   localparam logic [7:0] CHAR_PRINT_HIGH  = 8'd126;
   localparam logic [6:0] CHAR_SPACE       = 7'd32;

   // Depth of the token queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

   // One classified byte: either a printable character or a line terminator.
   typedef struct packed {
      logic       is_term;
      logic [6:0] ch;
   } token_type;

   // Token channel from the queue to the back.
   typedef struct packed {
      logic      valid;
      token_type token;
   } tok_chan_type;

   // Status of the back part.
   typedef struct packed {
      logic busy;
      logic tok_pop;
   } back_status_type;

endpackage

@@ src/line_trim_echo.sv @@
// Flow: a printable or terminator byte enters the token queue when it is accepted; on a
// terminator the back echoes the trimmed line, each character by a store read, then a load.
// Throughput: one byte per cycle while the 4-entry token queue has room; the back drains
// one token per cycle while idle, takes no tokens during an echo, and waits for a free slot.
// Reset: synchronous, active high; clears queue, line tracking and output register.
// The line store is not cleared and needs no clearing pass.
module line_trim_echo
   import lte_pkg::*;
#(
   parameter int unsigned LINE_STORE_BYTES = 64
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] req_rx_byte,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_of_line
);

   tok_chan_type    tok_chan;
   back_status_type back_status;

   // Front: accepts and classifies received bytes.
   lte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_rx_byte (req_rx_byte),
      .full        (full),
      .tok_pop     (back_status.tok_pop),
      .tok_chan    (tok_chan)
   );

   // Back: collects the line and echoes it trimmed.
   lte_back #(
      .LINE_STORE_BYTES (LINE_STORE_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .tok_chan         (tok_chan),
      .status           (back_status),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_of_line (rsp_last_of_line)
   );

   // An echoed character is always printable.
   a_out_printable: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_out_char >= 7'd32) && (rsp_out_char <= 7'd126))
      else $error("echoed character outside the printable range");

   // The queue is empty right after reset.
   a_reset_not_full: assert property (@(posedge clock)
      reset |=> !full)
      else $error("queue full after reset");

   // No token is consumed while a line is being echoed.
   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !back_status.tok_pop)
      else $error("token consumed during echo");

   // A waiting result stays put until its transaction completes.
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_out_char) && $stable(rsp_last_of_line))
      else $error("waiting result changed before it was taken");

endmodule

@@ src/lte_queue.sv @@
module lte_queue
   import lte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  token_type    wr_token,
   output logic         q_full,
   input  logic         rd_pop,
   output tok_chan_type rd_chan
);

   token_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     count_ff;
   logic                     do_wr;
   logic                     do_rd;

   // Full and empty flags come straight from the occupancy count.
   assign q_full        = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign rd_chan.valid = (count_ff != '0);
   assign rd_chan.token = entry_ff[rd_ptr_ff];

   assign do_wr = wr_en && !q_full;
   assign do_rd = rd_pop && rd_chan.valid;

   // Pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_token;
      end
   end

endmodule

@@ src/lte_front.sv @@
module lte_front
   import lte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [7:0]   req_rx_byte,
   output logic         full,
   input  logic         tok_pop,
   output tok_chan_type tok_chan
);

   logic      is_term;
   logic      is_print;
   logic      keep;
   token_type token;

   // Classify the byte; anything that is neither printable nor a terminator is dropped here.
   assign is_term  = (req_rx_byte == CHAR_LF) || (req_rx_byte == CHAR_CR);
   assign is_print = (req_rx_byte >= CHAR_PRINT_LOW) && (req_rx_byte <= CHAR_PRINT_HIGH);
   assign keep     = push && (is_term || is_print);

   assign token.is_term = is_term;
   assign token.ch      = req_rx_byte[6:0];

   // The queue decouples the front from the back.
   lte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (keep),
      .wr_token (token),
      .q_full   (full),
      .rd_pop   (tok_pop),
      .rd_chan  (tok_chan)
   );

endmodule

@@ src/lte_back.sv @@
module lte_back
   import lte_pkg::*;
#(
   parameter int unsigned LINE_STORE_BYTES = 64
)
(
   input  logic            clock,
   input  logic            reset,
   input  tok_chan_type    tok_chan,
   output back_status_type status,
   output logic            empty,
   input  logic            pop,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last_of_line
);

   localparam int unsigned     PW  = $clog2(LINE_STORE_BYTES);
   localparam int unsigned     CAP = LINE_STORE_BYTES - 1;
   localparam logic [PW-1:0]   CAP_POS = PW'(CAP);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_SEND
   } state_type;

   state_type         state_ff;
   logic [6:0]        store_ff [CAP];
   logic [6:0]        rd_data_ff;
   logic [PW-1:0]     fill_ff;
   logic [PW-1:0]     first_ff;
   logic [PW-1:0]     last_ff;
   logic              seen_ff;
   logic [PW-1:0]     pos_ff;
   logic [PW-1:0]     end_ff;
   logic              out_valid_ff;
   logic [6:0]        out_char_ff;
   logic              out_last_ff;
   logic              tok_pop;
   logic              store_wr;
   logic              slot_free;
   logic              out_load;

   // Tokens are taken only while no line is being echoed.
   assign tok_pop   = (state_ff == ST_IDLE) && tok_chan.valid;
   assign store_wr  = tok_pop && !tok_chan.token.is_term && (fill_ff < CAP_POS);
   assign slot_free = !out_valid_ff || pop;
   assign out_load  = (state_ff == ST_SEND) && slot_free;

   assign status.busy    = (state_ff != ST_IDLE);
   assign status.tok_pop = tok_pop;

   assign empty            = !out_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_last_of_line = out_last_ff;

   // Line store: one write port for collection, one registered read port for echo.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[fill_ff] <= tok_chan.token.ch;
      end
      rd_data_ff <= store_ff[pos_ff];
   end

   // Line tracking, echo sequencing and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         pos_ff       <= '0;
         end_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_char_ff  <= '0;
         out_last_ff  <= 1'b0;
      end else begin
         // A new load takes priority over the transaction that frees the slot.
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (tok_pop) begin
                  if (tok_chan.token.is_term) begin
                     // A terminator starts the echo if the line holds any non-space character.
                     if (seen_ff) begin
                        pos_ff   <= first_ff;
                        end_ff   <= last_ff;
                        state_ff <= ST_WAIT;
                     end
                     fill_ff  <= '0;
                     first_ff <= '0;
                     last_ff  <= '0;
                     seen_ff  <= 1'b0;
                  end else if (store_wr) begin
                     if (tok_chan.token.ch != CHAR_SPACE) begin
                        if (!seen_ff) begin
                           first_ff <= fill_ff;
                           seen_ff  <= 1'b1;
                        end
                        last_ff <= fill_ff;
                     end
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            end
            ST_WAIT: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (slot_free) begin
                  out_char_ff  <= rd_data_ff;
                  out_last_ff  <= (pos_ff == end_ff);
                  if (pos_ff == end_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= ST_WAIT;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
